@@ rtl/core/six_axis_block_average_magnitude_assert.svh @@
// Assertion macros for the six-axis block averager checker.
// Included by the checker file; no other dependencies.
`ifndef SIX_AXIS_BLOCK_AVERAGE_MAGNITUDE_ASSERT_SVH
`define SIX_AXIS_BLOCK_AVERAGE_MAGNITUDE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SABAM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define SABAM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/sabam_pkg.sv @@
// Shared types and constants for the six-axis block averager.
// No dependencies; imported by the top level, the lanes and the merge stage.
package sabam_pkg;

  localparam int NUM_AXES   = 6;
  localparam int SAMPLE_W   = 16;
  localparam int MEAN_W     = 32;
  localparam int SQ_W       = 64;
  localparam int QUO_W      = 56;   // product width less the fixed /256
  localparam int DIV_STEPS  = 56;
  localparam int ROOT_STEPS = 32;
  localparam int STEP_W     = 6;

  // register indexes of the write port
  localparam logic [1:0] REG_BLOCK_LENGTH = 2'd0;
  localparam logic [1:0] REG_ACCEL_XY     = 2'd1;
  localparam logic [1:0] REG_ACCEL_Z      = 2'd2;
  localparam logic [1:0] REG_GYRO         = 2'd3;

  // register values after reset
  localparam logic [15:0] RST_BLOCK_LENGTH = 16'd1000;
  localparam logic [31:0] RST_ACCEL_XY     = 32'd10045;
  localparam logic [31:0] RST_ACCEL_Z      = 32'd572590;
  localparam logic [31:0] RST_GYRO         = 32'd128000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_SAT,
    ST_SQR,
    ST_SUM,
    ST_RINIT,
    ST_ROOT,
    ST_DONE
  } state_t;

  // per-lane strobes from the sequencer
  typedef struct packed {
    logic add;
    logic mult;
    logic div_step;
    logic sat;
    logic square;
  } lane_ctrl_t;

  // merge and root strobes
  typedef struct packed {
    logic sum_ab;
    logic init;
    logic step;
  } root_ctrl_t;

endpackage

@@ rtl/core/six_axis_block_average_magnitude.sv @@
// Top level of the six-axis block averager: registers, sequencer, lanes, output.
// Depends on sabam_pkg, sabam_lane and sabam_root.

// Each sample is summed per axis in six lanes. A sample that does not close a
// block leaves s_tready high. The sample that closes a block starts the
// report: s_tready then stays low through the multiply, the 56-step serial
// divider in each lane, saturate, square, the two sums and the 32-step square
// root of the merge stage, and through the output load, which waits while a
// stalled report holds the output register. A report waits in the output
// register; a new block may close meanwhile, and its report is held until the
// previous one has transferred. A block length of zero acts as one. No clearing pass after reset.
module six_axis_block_average_magnitude import sabam_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z (16 bits each)
  input  logic [95:0]  s_tdata,
  // output stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // mean_accel_x, mean_accel_y, mean_accel_z, mean_rate_x, mean_rate_y,
  // mean_rate_z, accel_magnitude (32 bits each)
  output logic [223:0] m_tdata,
  // register write port
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  logic [15:0] block_length;
  logic [31:0] accel_xy_scale;
  logic [31:0] accel_z_scale;
  logic [31:0] gyro_scale;

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;
  logic [15:0]       sample_count;
  logic [15:0]       count_inc;
  logic [15:0]       len_eff;
  logic              in_xfer;
  logic              closes_block;
  logic              load_out;

  lane_ctrl_t        lane_ctrl;
  root_ctrl_t        root_ctrl;
  logic [MEAN_W-1:0] means [NUM_AXES];
  logic [SQ_W-1:0]   squares [NUM_AXES];
  logic [MEAN_W-1:0] magnitude;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      block_length   <= RST_BLOCK_LENGTH;
      accel_xy_scale <= RST_ACCEL_XY;
      accel_z_scale  <= RST_ACCEL_Z;
      gyro_scale     <= RST_GYRO;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLOCK_LENGTH: block_length   <= cfg_data[15:0];
        REG_ACCEL_XY:     accel_xy_scale <= cfg_data;
        REG_ACCEL_Z:      accel_z_scale  <= cfg_data;
        REG_GYRO:         gyro_scale     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign len_eff      = (block_length == 16'd0) ? 16'd1 : block_length;
  assign in_xfer      = s_tvalid && s_tready;
  assign count_inc    = sample_count + 16'd1;
  assign closes_block = count_inc >= len_eff;

  // sample counter
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
    end else if (in_xfer) begin
      sample_count <= closes_block ? 16'd0 : count_inc;
    end
  end

  // sequencer state and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= (state_next != state) ? '0 : step + STEP_W'(1);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_xfer && closes_block) state_next = ST_MUL;
      ST_MUL:   state_next = ST_DIV;
      ST_DIV:   if (step == STEP_W'(DIV_STEPS - 1)) state_next = ST_SAT;
      ST_SAT:   state_next = ST_SQR;
      ST_SQR:   state_next = ST_SUM;
      ST_SUM:   state_next = ST_RINIT;
      ST_RINIT: state_next = ST_ROOT;
      ST_ROOT:  if (step == STEP_W'(ROOT_STEPS - 1)) state_next = ST_DONE;
      ST_DONE:  if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready           = (state == ST_IDLE);
    lane_ctrl.add      = in_xfer;
    lane_ctrl.mult     = (state == ST_MUL);
    lane_ctrl.div_step = (state == ST_DIV);
    lane_ctrl.sat      = (state == ST_SAT);
    lane_ctrl.square   = (state == ST_SQR);
    root_ctrl.sum_ab   = (state == ST_SUM);
    root_ctrl.init     = (state == ST_RINIT);
    root_ctrl.step     = (state == ST_ROOT);
    load_out           = (state == ST_DONE) && (!m_tvalid || m_tready);
  end

  // one lane per axis
  for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
    logic [31:0] lane_scale;
    assign lane_scale = (i < 2) ? accel_xy_scale :
                        (i == 2) ? accel_z_scale : gyro_scale;

    sabam_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (lane_ctrl),
      .sample  (s_tdata[SAMPLE_W*i +: SAMPLE_W]),
      .scale   (lane_scale),
      .divisor (len_eff),
      .mean    (means[i]),
      .square  (squares[i])
    );
  end

  sabam_root u_root (
    .clk  (clk),
    .ctrl (root_ctrl),
    .sq_a (squares[0]),
    .sq_b (squares[1]),
    .sq_c (squares[2]),
    .root (magnitude)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {magnitude, means[5], means[4], means[3], means[2], means[1], means[0]};
    end
  end

endmodule

@@ rtl/core/sabam_lane.sv @@
// One axis lane: running sum, scale multiply, serial divide, saturation, square.
// Depends on sabam_pkg.
module sabam_lane import sabam_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  lane_ctrl_t                 ctrl,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [31:0]                scale,
  input  logic [15:0]                divisor,
  output logic [MEAN_W-1:0]          mean,
  output logic [SQ_W-1:0]            square
);

  logic [31:0]      sum;
  logic             neg;
  logic [QUO_W-1:0] quo;
  logic [15:0]      rem;

  logic [31:0]      sum_mag;
  logic [31:0]      mean_mag;
  logic [31:0]      op_a;
  logic [31:0]      op_b;
  logic [63:0]      prod;
  logic [16:0]      shifted;
  logic [16:0]      trial;
  logic [MEAN_W-1:0] mean_next;

  // magnitudes; the most negative value maps to 2^31 by wrap
  assign sum_mag  = sum[31] ? (~sum + 32'd1) : sum;
  assign mean_mag = mean[31] ? (~mean + 32'd1) : mean;

  // one multiplier, shared between the scale product and the square
  assign op_a = ctrl.square ? mean_mag : sum_mag;
  assign op_b = ctrl.square ? mean_mag : scale;
  assign prod = op_a * op_b;

  // restoring divide, one quotient bit per step
  assign shifted = {rem, quo[QUO_W-1]};
  assign trial   = shifted - {1'b0, divisor};

  // saturate and apply sign
  always_comb begin
    if (neg) begin
      if (quo > QUO_W'(32'h8000_0000)) mean_next = 32'h8000_0000;
      else                             mean_next = 32'd0 - quo[31:0];
    end else begin
      if (quo > QUO_W'(32'h7FFF_FFFF)) mean_next = 32'h7FFF_FFFF;
      else                             mean_next = quo[31:0];
    end
  end

  // running sum, cleared once the block is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctrl.add) begin
      sum <= sum + {{(32-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
    end else if (ctrl.mult) begin
      sum <= '0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (ctrl.mult) begin
      neg <= sum[31];
      quo <= prod[63:8];
      rem <= '0;
    end else if (ctrl.div_step) begin
      if (!trial[16]) begin
        rem <= trial[15:0];
        quo <= {quo[QUO_W-2:0], 1'b1};
      end else begin
        rem <= shifted[15:0];
        quo <= {quo[QUO_W-2:0], 1'b0};
      end
    end
    if (ctrl.sat) begin
      mean <= mean_next;
    end
    if (ctrl.square) begin
      square <= prod;
    end
  end

endmodule

@@ rtl/core/sabam_root.sv @@
// Merge stage: adds the three accel squares and takes the floor square root.
// Depends on sabam_pkg.
module sabam_root import sabam_pkg::*; (
  input  logic              clk,
  input  root_ctrl_t        ctrl,
  input  logic [SQ_W-1:0]   sq_a,
  input  logic [SQ_W-1:0]   sq_b,
  input  logic [SQ_W-1:0]   sq_c,
  output logic [MEAN_W-1:0] root
);

  logic [SQ_W-1:0] partial;
  logic [SQ_W-1:0] rad;
  logic [SQ_W-1:0] res;
  logic [SQ_W-1:0] probe;
  logic [SQ_W-1:0] trial;

  assign trial = res + probe;
  assign root  = res[MEAN_W-1:0];

  // sum of a and b, then of c, then bit-pair square root
  always_ff @(posedge clk) begin
    if (ctrl.sum_ab) begin
      partial <= sq_a + sq_b;
    end
    if (ctrl.init) begin
      rad   <= partial + sq_c;
      res   <= '0;
      probe <= SQ_W'(1) << (SQ_W - 2);
    end else if (ctrl.step) begin
      if (rad >= trial) begin
        rad <= rad - trial;
        res <= (res >> 1) + probe;
      end else begin
        res <= res >> 1;
      end
      probe <= probe >> 2;
    end
  end

endmodule

@@ rtl/core/sabam_checker.sv @@
// Port-level checks for the six-axis block averager, bound to the top level.
// Depends on the assertion macro header.
`include "six_axis_block_average_magnitude_assert.svh"

module sabam_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [223:0] m_tdata
);

  logic [31:0] mean_x;
  logic [31:0] abs_x;

  assign mean_x     = m_tdata[31:0];
  assign abs_x      = mean_x[31] ? (~mean_x + 32'd1) : mean_x;

  // a stalled report holds
  `SABAM_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "report changed while stalled")

  // a report is only produced after a busy phase with the input closed
  `SABAM_ASSERT_IMP(a_report_after_busy, clk, rst, $rose(m_tvalid), !$past(s_tready), "report without a busy phase")

  // the input closes only after a sample transfer
  `SABAM_ASSERT_IMP(a_busy_after_xfer, clk, rst, $fell(s_tready), $past(s_tvalid && s_tready), "input closed without a transfer")

  // the magnitude covers the x component
  `SABAM_ASSERT_IMP(a_mag_bound, clk, rst, m_tvalid, m_tdata[223:192] >= abs_x, "magnitude below accel x mean")

endmodule

bind six_axis_block_average_magnitude sabam_checker u_sabam_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
